@@ src/fun_pkg.sv @@
// ----------------------------------------------------------------------------
// fun_pkg
// shared types for the facet unit normal pipeline
// ----------------------------------------------------------------------------
package fun_pkg;

    localparam int AXES = 3;

    // per-facet flags that ride along with the data
    typedef struct packed {
        logic [AXES-1:0] neg;
        logic            deg;
    } t_flags;

endpackage

@@ src/fun_vtx_if.sv @@
// ----------------------------------------------------------------------------
// fun_vtx_if
// facet vertex channel: three vertices, signed fixed point
// ----------------------------------------------------------------------------
interface fun_vtx_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex0_x;
    logic signed [COORD_BITS-1:0] vertex0_y;
    logic signed [COORD_BITS-1:0] vertex0_z;
    logic signed [COORD_BITS-1:0] vertex1_x;
    logic signed [COORD_BITS-1:0] vertex1_y;
    logic signed [COORD_BITS-1:0] vertex1_z;
    logic signed [COORD_BITS-1:0] vertex2_x;
    logic signed [COORD_BITS-1:0] vertex2_y;
    logic signed [COORD_BITS-1:0] vertex2_z;

    modport source (
        output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z,
        input  ready
    );
    modport sink (
        input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z,
        output ready
    );
endinterface

@@ src/fun_nrm_if.sv @@
// ----------------------------------------------------------------------------
// fun_nrm_if
// unit normal channel: three signed components and a degenerate flag
// ----------------------------------------------------------------------------
interface fun_nrm_if #(
    parameter int OUT_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] normal_x;
    logic signed [OUT_BITS-1:0] normal_y;
    logic signed [OUT_BITS-1:0] normal_z;
    logic                       degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

@@ src/fun_cross.sv @@
// ----------------------------------------------------------------------------
// fun_cross
// edges, cross product, component magnitudes and squared length (5 stages)
// ----------------------------------------------------------------------------
module fun_cross #(
    parameter int COORD_BITS = 16,
    parameter int MW         = 35,
    parameter int SW         = 72
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_vert [9],
    output logic                         o_valid,
    output logic [SW-1:0]                o_sum,
    output logic [2:0][MW-1:0]           o_mag,
    output fun_pkg::t_flags              o_flags
);
    import fun_pkg::*;

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int QW = 2 * MW;

    logic [4:0]              r_vld;
    logic signed [EW-1:0]    r_e1 [AXES];
    logic signed [EW-1:0]    r_e2 [AXES];
    logic signed [PW-1:0]    r_p [6];
    logic [2:0][MW-1:0]      r_m1;
    logic [2:0]              r_neg1;
    logic [QW-1:0]           r_sq [AXES];
    logic [2:0][MW-1:0]      r_m2;
    logic [2:0]              r_neg2;
    logic                    r_zero2;
    logic [SW-1:0]           r_sum;
    logic [2:0][MW-1:0]      r_m3;
    t_flags                  r_flags;
    logic signed [MW-1:0]    n_c [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_c[a] = MW'(r_p[2*a]) - MW'(r_p[2*a+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < AXES; a++) begin
                r_e1[a] <= EW'(i_vert[3+a]) - EW'(i_vert[a]);
                r_e2[a] <= EW'(i_vert[6+a]) - EW'(i_vert[a]);
            end
            // cross product terms
            r_p[0] <= PW'(r_e1[1]) * PW'(r_e2[2]);
            r_p[1] <= PW'(r_e1[2]) * PW'(r_e2[1]);
            r_p[2] <= PW'(r_e1[2]) * PW'(r_e2[0]);
            r_p[3] <= PW'(r_e1[0]) * PW'(r_e2[2]);
            r_p[4] <= PW'(r_e1[0]) * PW'(r_e2[1]);
            r_p[5] <= PW'(r_e1[1]) * PW'(r_e2[0]);
            for (int a = 0; a < AXES; a++) begin
                r_neg1[a] <= n_c[a][MW-1];
                r_m1[a]   <= n_c[a][MW-1] ? MW'(-n_c[a]) : MW'(n_c[a]);
                r_sq[a]   <= QW'(r_m1[a]) * QW'(r_m1[a]);
            end
            r_m2    <= r_m1;
            r_neg2  <= r_neg1;
            r_zero2 <= (r_m1 == '0);
            r_sum   <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_m3    <= r_m2;
            r_flags <= '{neg: r_neg2, deg: r_zero2};
        end
    end

    assign o_valid = r_vld[4];
    assign o_sum   = r_sum;
    assign o_mag   = r_m3;
    assign o_flags = r_flags;

endmodule

@@ src/fun_isqrt.sv @@
// ----------------------------------------------------------------------------
// fun_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module fun_isqrt #(
    parameter int SW     = 72,
    parameter int PASS_W = 105
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SW-1:0]       i_sum,
    input  logic [PASS_W-1:0]   i_pass,
    input  fun_pkg::t_flags     i_flags,
    output logic                o_valid,
    output logic [SW/2-1:0]     o_root,
    output logic [PASS_W-1:0]   o_pass,
    output fun_pkg::t_flags     o_flags
);
    import fun_pkg::*;

    localparam int NS = SW / 2;

    logic [SW-1:0]     w_x [NS];
    logic [SW-1:0]     w_r [NS];
    logic [PASS_W-1:0] w_pass [NS];
    t_flags            w_flags [NS];
    logic              w_vld [NS];

    logic [SW-1:0]     r_x [NS-1];
    logic [SW-1:0]     r_r [NS];
    logic [PASS_W-1:0] r_pass [NS];
    t_flags            r_flags [NS];
    logic              r_vld [NS];

    assign w_x[0]     = i_sum;
    assign w_r[0]     = '0;
    assign w_pass[0]  = i_pass;
    assign w_flags[0] = i_flags;
    assign w_vld[0]   = i_valid;

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
        logic [SW-1:0] trial;
        logic          fits;

        if (k > 0) begin : g_link
            assign w_x[k]     = r_x[k-1];
            assign w_r[k]     = r_r[k-1];
            assign w_pass[k]  = r_pass[k-1];
            assign w_flags[k] = r_flags[k-1];
            assign w_vld[k]   = r_vld[k-1];
        end

        assign trial = w_r[k] + BIT;
        assign fits  = (w_x[k] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[k]     <= fits ? ((w_r[k] >> 1) + BIT) : (w_r[k] >> 1);
                r_pass[k]  <= w_pass[k];
                r_flags[k] <= w_flags[k];
            end
        end

        // the remainder is not needed past the last stage
        if (k < NS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k] <= fits ? (w_x[k] - trial) : w_x[k];
                end
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_r[NS-1][NS-1:0];
    assign o_pass  = r_pass[NS-1];
    assign o_flags = r_flags[NS-1];

endmodule

@@ src/fun_div.sv @@
// ----------------------------------------------------------------------------
// fun_div
// three-lane restoring divider, one quotient bit per stage, signed output
// ----------------------------------------------------------------------------
module fun_div #(
    parameter int MW   = 35,
    parameter int LW   = 36,
    parameter int FRAC = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [LW-1:0]          i_len,
    input  logic [2:0][MW-1:0]     i_mag,
    input  fun_pkg::t_flags        i_flags,
    output logic                   o_valid,
    output logic signed [FRAC+1:0] o_norm [3],
    output logic                   o_deg
);
    import fun_pkg::*;

    localparam int ND = FRAC + 1;
    localparam int RW = LW + FRAC + 1;
    localparam int OW = FRAC + 2;

    logic [2:0][RW-1:0] w_rem [ND];
    logic [2:0][FRAC:0] w_q [ND];
    logic [LW-1:0]      w_len [ND];
    t_flags             w_flags [ND];
    logic               w_vld [ND];

    logic [2:0][RW-1:0] r_rem [ND-1];
    logic [2:0][FRAC:0] r_q [ND];
    logic [LW-1:0]      r_len [ND];
    t_flags             r_flags [ND];
    logic               r_vld [ND];

    logic signed [OW-1:0] r_norm [AXES];
    logic                 r_deg;
    logic                 r_out_vld;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_rem[0][a] = RW'(i_mag[a]) << FRAC;
        end
    end
    assign w_q[0]     = '0;
    assign w_len[0]   = i_len;
    assign w_flags[0] = i_flags;
    assign w_vld[0]   = i_valid;

    for (genvar k = 0; k < ND; k++) begin : g_stage
        localparam int B = FRAC - k;
        logic [RW-1:0] dv;
        logic [2:0]    fits;

        if (k > 0) begin : g_link
            assign w_rem[k]   = r_rem[k-1];
            assign w_q[k]     = r_q[k-1];
            assign w_len[k]   = r_len[k-1];
            assign w_flags[k] = r_flags[k-1];
            assign w_vld[k]   = r_vld[k-1];
        end

        assign dv = RW'(w_len[k]) << B;

        always_comb begin
            for (int a = 0; a < AXES; a++) begin
                fits[a] = (w_rem[k][a] >= dv);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int a = 0; a < AXES; a++) begin
                    r_q[k][a] <= fits[a] ? (w_q[k][a] | ((FRAC+1)'(1) << B)) : w_q[k][a];
                end
                r_len[k]   <= w_len[k];
                r_flags[k] <= w_flags[k];
            end
        end

        if (k < ND - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int a = 0; a < AXES; a++) begin
                        r_rem[k][a] <= fits[a] ? (w_rem[k][a] - dv) : w_rem[k][a];
                    end
                end
            end
        end
    end

    // output register: apply sign, force zeros for a degenerate facet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[ND-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < AXES; a++) begin
                if (r_flags[ND-1].deg) begin
                    r_norm[a] <= '0;
                end else if (r_flags[ND-1].neg[a]) begin
                    r_norm[a] <= -OW'(r_q[ND-1][a]);
                end else begin
                    r_norm[a] <= OW'(r_q[ND-1][a]);
                end
            end
            r_deg <= r_flags[ND-1].deg;
        end
    end

    assign o_valid = r_out_vld;
    assign o_norm  = r_norm;
    assign o_deg   = r_deg;

endmodule

@@ src/facet_unit_normal.sv @@
// ----------------------------------------------------------------------------
// facet_unit_normal
// unit normal of a triangular facet from its three vertices
// ----------------------------------------------------------------------------
// Takes one facet per clock while the output is not held off, and returns one
// result per facet, in order. Five stages form the edges, the cross product and
// the squared length, the integer square root resolves one bit per stage, and
// each of three divider lanes resolves one quotient bit per stage, then a
// final register applies the sign. When the output is held off, the whole
// pipeline stalls in place; nothing is dropped. A facet whose cross product
// is zero comes out with a zero normal and degenerate set.
module facet_unit_normal #(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fun_vtx_if.sink  i_vtx,
    fun_nrm_if.source o_nrm
);
    import fun_pkg::*;

    localparam int EW     = COORD_BITS + 1;
    localparam int MW     = 2 * EW + 1;
    localparam int SW     = 2 * MW + 2;
    localparam int LW     = SW / 2;
    localparam int OW     = NORMAL_FRAC_BITS + 2;
    localparam int PASS_W = AXES * MW;

    logic                         en;
    logic signed [COORD_BITS-1:0] vert [9];

    logic                 x_valid;
    logic [SW-1:0]        x_sum;
    logic [2:0][MW-1:0]   x_mag;
    t_flags               x_flags;

    logic                 s_valid;
    logic [LW-1:0]        s_root;
    logic [PASS_W-1:0]    s_pass;
    logic [2:0][MW-1:0]   s_mag;
    t_flags               s_flags;

    logic                 d_valid;
    logic signed [OW-1:0] d_norm [AXES];
    logic                 d_deg;

    // the pipeline advances whenever the output register can move
    assign en          = !d_valid || o_nrm.ready;
    assign i_vtx.ready = en;

    assign vert[0] = i_vtx.vertex0_x;
    assign vert[1] = i_vtx.vertex0_y;
    assign vert[2] = i_vtx.vertex0_z;
    assign vert[3] = i_vtx.vertex1_x;
    assign vert[4] = i_vtx.vertex1_y;
    assign vert[5] = i_vtx.vertex1_z;
    assign vert[6] = i_vtx.vertex2_x;
    assign vert[7] = i_vtx.vertex2_y;
    assign vert[8] = i_vtx.vertex2_z;

    fun_cross #(
        .COORD_BITS (COORD_BITS),
        .MW         (MW),
        .SW         (SW)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_vtx.valid),
        .i_vert  (vert),
        .o_valid (x_valid),
        .o_sum   (x_sum),
        .o_mag   (x_mag),
        .o_flags (x_flags)
    );

    fun_isqrt #(
        .SW     (SW),
        .PASS_W (PASS_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (x_valid),
        .i_sum   (x_sum),
        .i_pass  (x_mag),
        .i_flags (x_flags),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_pass  (s_pass),
        .o_flags (s_flags)
    );

    assign s_mag = s_pass;

    fun_div #(
        .MW   (MW),
        .LW   (LW),
        .FRAC (NORMAL_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_len   (s_root),
        .i_mag   (s_mag),
        .i_flags (s_flags),
        .o_valid (d_valid),
        .o_norm  (d_norm),
        .o_deg   (d_deg)
    );

    assign o_nrm.valid      = d_valid;
    assign o_nrm.normal_x   = d_norm[0];
    assign o_nrm.normal_y   = d_norm[1];
    assign o_nrm.normal_z   = d_norm[2];
    assign o_nrm.degenerate = d_deg;

    localparam logic signed [OW-1:0] ONE = OW'(1) << NORMAL_FRAC_BITS;

    // a degenerate facet carries an all-zero normal
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_nrm.valid && o_nrm.degenerate) |->
            (o_nrm.normal_x == '0 && o_nrm.normal_y == '0 && o_nrm.normal_z == '0))
        else $error("degenerate facet with nonzero normal");

    // a real facet never comes out with an all-zero normal
    a_live_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_nrm.valid && !o_nrm.degenerate) |->
            (o_nrm.normal_x != '0 || o_nrm.normal_y != '0 || o_nrm.normal_z != '0))
        else $error("nondegenerate facet with zero normal");

    // components stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_nrm.valid |->
            (o_nrm.normal_x <= ONE && o_nrm.normal_x >= -ONE &&
             o_nrm.normal_y <= ONE && o_nrm.normal_y >= -ONE &&
             o_nrm.normal_z <= ONE && o_nrm.normal_z >= -ONE))
        else $error("normal component out of range");

    // a stalled result stays valid, and its x component stays put while the pipeline is frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_nrm.valid && !o_nrm.ready) |=> (o_nrm.valid && $stable(d_norm[0])))
        else $error("result changed under stall");

endmodule

@@ tb/facet_unit_normal_tb.sv @@
// ----------------------------------------------------------------------------
// facet_unit_normal_tb
// checks the facet unit normal pipeline against an exact integer predictor
// under random idling on both channels
// ----------------------------------------------------------------------------

class normal_scoreboard;
    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               deg;
    } t_normal;

    t_normal pending[$];
    int      mismatches;

    function new();
        mismatches = 0;
    endfunction

    // floor square root of a nonnegative value below 2^128
    function automatic logic [63:0] isqrt(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= s) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] scale(logic signed [63:0] c,
                                                 logic [63:0] len);
        logic [127:0] mag;
        logic [127:0] q;
        mag = c < 0 ? -c : c;
        q   = (mag << 14) / len;
        return c < 0 ? -q[15:0] : q[15:0];
    endfunction

    function void note_facet(logic signed [15:0] v[9]);
        logic signed [63:0]  e1[3];
        logic signed [63:0]  e2[3];
        logic signed [63:0]  c[3];
        logic [127:0]        s;
        logic [63:0]         len;
        t_normal             n;
        for (int i = 0; i < 3; i++) begin
            e1[i] = 64'(v[3+i]) - 64'(v[i]);
            e2[i] = 64'(v[6+i]) - 64'(v[i]);
        end
        c[0] = e1[1]*e2[2] - e1[2]*e2[1];
        c[1] = e1[2]*e2[0] - e1[0]*e2[2];
        c[2] = e1[0]*e2[1] - e1[1]*e2[0];
        s = '0;
        // squares reach 2^66, so they are formed at full width
        for (int i = 0; i < 3; i++) s += 128'(c[i]) * 128'(c[i]);
        if (s == 0) begin
            n = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        end else begin
            len = isqrt(s);
            n = '{scale(c[0], len), scale(c[1], len), scale(c[2], len), 1'b0};
        end
        pending.push_back(n);
    endfunction

    function void check_normal(t_normal got);
        t_normal want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %p", got);
            return;
        end
        want = pending.pop_front();
        if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
    endfunction
endclass

module facet_unit_normal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    bit   no_idle;

    fun_vtx_if #(.COORD_BITS(16)) vtx ();
    fun_nrm_if #(.OUT_BITS(16))   nrm ();

    facet_unit_normal u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx.sink),
        .o_nrm   (nrm.source)
    );

    normal_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side: sample at rising edge, change ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && nrm.valid && nrm.ready)
            sb.check_normal('{nrm.normal_x, nrm.normal_y, nrm.normal_z, nrm.degenerate});
    end

    always @(negedge i_clk) begin
        nrm.ready <= no_idle || ($urandom_range(99) >= 28);
    end

    // called at a falling edge; valid stays high into the next beat unless idling
    task automatic send_facet(logic signed [15:0] v[9]);
        while (!no_idle && $urandom_range(99) < 28) begin
            vtx.valid <= 1'b0;
            @(negedge i_clk);
        end
        vtx.valid     <= 1'b1;
        vtx.vertex0_x <= v[0]; vtx.vertex0_y <= v[1]; vtx.vertex0_z <= v[2];
        vtx.vertex1_x <= v[3]; vtx.vertex1_y <= v[4]; vtx.vertex1_z <= v[5];
        vtx.vertex2_x <= v[6]; vtx.vertex2_y <= v[7]; vtx.vertex2_z <= v[8];
        do @(posedge i_clk); while (!vtx.ready);
        sb.note_facet(v);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] pick();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic signed [15:0] v[9];
        cycles    = 0;
        no_idle   = 1'b0;
        i_rst_n   = 1'b0;
        vtx.valid = 1'b0;
        nrm.ready = 1'b0;
        {vtx.vertex0_x, vtx.vertex0_y, vtx.vertex0_z} = '0;
        {vtx.vertex1_x, vtx.vertex1_y, vtx.vertex1_z} = '0;
        {vtx.vertex2_x, vtx.vertex2_y, vtx.vertex2_z} = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: coincident, collinear, axis-aligned, extremes
        v = '{default: 16'sd0};                                    send_facet(v);
        v = '{16'sd1, 16'sd1, 16'sd1, 16'sd2, 16'sd2, 16'sd2,
              16'sd3, 16'sd3, 16'sd3};                             send_facet(v);
        v = '{0, 0, 0, 256, 0, 0, 0, 256, 0};                      send_facet(v);
        v = '{0, 0, 0, 0, 256, 0, 0, 0, 256};                      send_facet(v);
        v = '{0, 0, 0, 0, 0, 256, 256, 0, 0};                      send_facet(v);
        v = '{0, 0, 0, 0, 256, 0, 256, 0, 0};                      send_facet(v);
        v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh7fff, 16'sh8000};                    send_facet(v);
        v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh8000, 16'sh8000};                    send_facet(v);
        v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh8000, 16'sh8000, 16'sh7fff};                    send_facet(v);
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                          send_facet(v);
        v = '{0, 0, 0, 1, 1, 0, 1, 2, 0};                          send_facet(v);
        v = '{16'sh7fff, 0, 0, 16'sh8000, 0, 0, 0, 16'sh7fff, 0};  send_facet(v);

        for (int n = 0; n < 1650; n++) begin
            no_idle = (n >= 700 && n < 900);
            for (int k = 0; k < 9; k++) v[k] = pick();
            // some collinear facets: third vertex on the line of the first edge, where it does not wrap
            if ($urandom_range(19) == 0)
                for (int k = 0; k < 3; k++) v[6+k] = v[k] + 2*(v[3+k] - v[k]);
            send_facet(v);
        end
        vtx.valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ facet_unit_normal.f @@
src/fun_pkg.sv
src/fun_vtx_if.sv
src/fun_nrm_if.sv
src/fun_cross.sv
src/fun_isqrt.sv
src/fun_div.sv
src/facet_unit_normal.sv
tb/facet_unit_normal_tb.sv
